### sv/mfnb_pkg.sv
// Package for the mesh facet normal and bounds unit.
// Holds shared widths, codes, payload structs and magnitude helpers; no dependencies.
package mfnb_pkg;

  localparam int COUNT_BITS = 24;
  localparam int SUM_BITS   = 58;
  localparam int CDEN_BITS  = COUNT_BITS + 2;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_MIN    = 2'd1;
  localparam logic [1:0] KIND_MAX    = 2'd2;
  localparam logic [1:0] KIND_CENTER = 2'd3;

  localparam logic [7:0] CFG_FACET_COUNT    = 8'd0;
  localparam logic [7:0] CFG_NORMAL_EPSILON = 8'd1;

  typedef struct packed {
    logic [2:0][31:0]      nrm;
    logic [2:0][2:0][31:0] vtx;
  } facet_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [2:0][31:0] pos;
    logic [2:0][15:0] unit;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] facet_count;
    logic [15:0]           normal_epsilon;
  } cfg_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

endpackage

### sv/mesh_facet_normal_bounds_unit.sv
// Top level of the mesh facet normal and bounds unit.
// Depends on mfnb_pkg, mfnb_front, mfnb_back and mfnb_outq.
//
// Usage:
//  - Facets enter through a queue interface: an item transfers on a clock edge with
//    push high and full low. A two-entry input queue parts the push side from the
//    sequencer.
//  - Results leave through a queue interface: the oldest result sits on the result
//    ports while empty is low and transfers on an edge with pop high. A four-entry
//    result queue lets the sequencer keep working while the receiver stalls; when it
//    fills, the sequencer holds and then the input queue fills and raises full.
//  - Configuration writes transfer on cfg_valid with cfg_ready (always high): index 0
//    sets facet_count, index 1 normal_epsilon, other indexes are dropped. Write only
//    while the unit is idle.
//  - Each facet gives three vertex results; the last facet of a mesh adds minimum,
//    maximum and centroid results.
//  - Sequencing: one facet at a time in the sequencer. A facet passes through take,
//    length, test, edge halving, cross, normalizing shifts, square root, three divides
//    and vertex output; the shared bit-serial divider takes most of the time. A zero
//    normal skips the square root and divides. A mesh end adds three centroid divides
//    and the summary results.
//  - Reset (rst, synchronous) empties both queues, restores facet_count and
//    normal_epsilon to one and clears the bounds, sums and facet counter.
module mesh_facet_normal_bounds_unit import mfnb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] normal_x,
  input  logic [31:0] normal_y,
  input  logic [31:0] normal_z,
  input  logic [31:0] vertex0_x,
  input  logic [31:0] vertex0_y,
  input  logic [31:0] vertex0_z,
  input  logic [31:0] vertex1_x,
  input  logic [31:0] vertex1_y,
  input  logic [31:0] vertex1_z,
  input  logic [31:0] vertex2_x,
  input  logic [31:0] vertex2_y,
  input  logic [31:0] vertex2_z,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [31:0] pos_x,
  output logic [31:0] pos_y,
  output logic [31:0] pos_z,
  output logic [15:0] unit_nx,
  output logic [15:0] unit_ny,
  output logic [15:0] unit_nz,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t    cfg;
  facet_t  in_facet;
  facet_t  facet;
  logic    facet_valid;
  logic    facet_take;
  logic    res_push;
  logic    res_full;
  result_t res_in;
  result_t res_out;

  assign cfg_ready = 1'b1;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.facet_count    <= COUNT_BITS'(1);
      cfg.normal_epsilon <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FACET_COUNT:    cfg.facet_count    <= cfg_data[COUNT_BITS-1:0];
        CFG_NORMAL_EPSILON: cfg.normal_epsilon <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign in_facet.nrm[0]    = normal_x;
  assign in_facet.nrm[1]    = normal_y;
  assign in_facet.nrm[2]    = normal_z;
  assign in_facet.vtx[0][0] = vertex0_x;
  assign in_facet.vtx[0][1] = vertex0_y;
  assign in_facet.vtx[0][2] = vertex0_z;
  assign in_facet.vtx[1][0] = vertex1_x;
  assign in_facet.vtx[1][1] = vertex1_y;
  assign in_facet.vtx[1][2] = vertex1_z;
  assign in_facet.vtx[2][0] = vertex2_x;
  assign in_facet.vtx[2][1] = vertex2_y;
  assign in_facet.vtx[2][2] = vertex2_z;

  mfnb_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_facet(in_facet),
    .facet_valid(facet_valid), .facet_take(facet_take), .facet(facet)
  );

  mfnb_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .facet_valid(facet_valid), .facet_take(facet_take),
    .facet(facet), .res_push(res_push), .res(res_in), .res_full(res_full)
  );

  mfnb_outq u_outq (
    .clk(clk), .rst(rst), .push(res_push), .in_res(res_in), .full(res_full),
    .empty(empty), .pop(pop), .res(res_out)
  );

  assign kind    = res_out.kind;
  assign pos_x   = res_out.pos[0];
  assign pos_y   = res_out.pos[1];
  assign pos_z   = res_out.pos[2];
  assign unit_nx = res_out.unit[0];
  assign unit_ny = res_out.unit[1];
  assign unit_nz = res_out.unit[2];
  assign last    = res_out.last;

endmodule

### sv/mfnb_front.sv
// Input queue of the facet unit: two facet entries between the push side and the sequencer.
// Depends on mfnb_pkg.
module mfnb_front import mfnb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  output logic   full,
  input  facet_t in_facet,
  output logic   facet_valid,
  input  logic   facet_take,
  output facet_t facet
);

  facet_t     entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_take;

  assign full        = (count == 2'd2);
  assign facet_valid = (count != 2'd0);
  assign facet       = entry[rd_ptr];
  assign do_push     = push && !full;
  assign do_take     = facet_take && facet_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_take};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= in_facet;
  end

endmodule

### sv/mfnb_outq.sv
// Result queue of the facet unit: four result entries ahead of the pop side.
// Depends on mfnb_pkg.
module mfnb_outq import mfnb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t in_res,
  output logic    full,
  output logic    empty,
  input  logic    pop,
  output result_t res
);

  result_t    entry [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 3'd4);
  assign empty   = (count == 3'd0);
  assign res     = entry[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 2'd1;
      if (do_pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'b0, do_push} - {2'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= in_res;
  end

endmodule

### sv/mfnb_div.sv
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 32-bit divisor.
// Depends on mfnb_pkg only by convention of the project.
module mfnb_div import mfnb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem, quo[63]};
  assign fits   = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 32'd0;
      quo <= num;
      dvs <= den;
    end else if (busy) begin
      rem <= fits ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
      quo <= {quo[62:0], fits};
    end
  end

endmodule

### sv/mfnb_sqrt.sv
// Bitwise integer square root of a 64-bit value, one result bit per cycle.
// Depends on mfnb_pkg only by convention of the project.
module mfnb_sqrt import mfnb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rem;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  assign trial = r + bitv;
  assign root  = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= x;
      r    <= 64'd0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        r   <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

### sv/mfnb_back.sv
// Facet sequencer: normal selection, normalization, vertex output, bounds and centroid.
// Depends on mfnb_pkg, mfnb_div and mfnb_sqrt.
module mfnb_back import mfnb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    facet_valid,
  output logic    facet_take,
  input  facet_t  facet,
  output logic    res_push,
  output result_t res,
  input  logic    res_full
);

  typedef enum logic [3:0] {
    S_IDLE, S_LEN, S_TEST, S_EDGE, S_CROSS, S_NORM, S_SS, S_SQRT_GO, S_SQRT_WAIT,
    S_DIV_GO, S_DIV_WAIT, S_VERT, S_CEN_GO, S_CEN_WAIT, S_SUM
  } state_t;

  localparam logic signed [32:0] E_LIM = 33'sd1073741824;
  localparam logic [63:0] M_LO = 64'd536870912;
  localparam logic [63:0] M_HI = 64'd1073741824;

  state_t state;
  logic [2:0] k;
  facet_t cur;
  logic signed [32:0] e [6];
  logic signed [63:0] vec [3];
  logic [63:0] ss;
  logic [31:0] len;
  logic [2:0][15:0] unitv;
  logic signed [31:0] bmin [3];
  logic signed [31:0] bmax [3];
  logic [SUM_BITS-1:0] sum [3];
  logic [COUNT_BITS-1:0] seen;
  logic [2:0][31:0] cen;
  logic [CDEN_BITS-1:0] cen_den;
  logic done_r;

  logic div_start;
  logic [63:0] div_num;
  logic [31:0] div_den;
  logic div_done;
  logic [63:0] div_q;
  logic sq_start;
  logic sq_done;
  logic [31:0] sq_root;

  logic [63:0] vmag [3];
  logic [63:0] m;
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] prod;
  logic big;
  logic [31:0] eps_sq;
  logic [COUNT_BITS-1:0] n_cnt;
  logic [COUNT_BITS-1:0] target;
  logic mesh_done;
  logic [COUNT_BITS:0] nn;
  logic [SUM_BITS-1:0] smag;
  logic [14:0] qclamp;
  logic [31:0] vsel [3];

  mfnb_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  mfnb_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .x(ss), .done(sq_done), .root(sq_root)
  );

  assign facet_take = (state == S_IDLE) && facet_valid;

  always_comb begin
    for (int i = 0; i < 3; i++) vmag[i] = mag64(vec[i]);
    m = vmag[0];
    if (vmag[1] > m) m = vmag[1];
    if (vmag[2] > m) m = vmag[2];
    big = 1'b0;
    for (int i = 0; i < 6; i++) big = big || (e[i] >= E_LIM) || (e[i] <= -E_LIM);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_LEN: begin
        mul_a = {2'b0, mag32(cur.nrm[k[1:0]])};
        mul_b = {2'b0, mag32(cur.nrm[k[1:0]])};
      end
      S_CROSS: begin
        case (k)
          3'd0:    begin mul_a = {e[1][32], e[1]}; mul_b = {e[5][32], e[5]}; end
          3'd1:    begin mul_a = {e[2][32], e[2]}; mul_b = {e[4][32], e[4]}; end
          3'd2:    begin mul_a = {e[2][32], e[2]}; mul_b = {e[3][32], e[3]}; end
          3'd3:    begin mul_a = {e[0][32], e[0]}; mul_b = {e[5][32], e[5]}; end
          3'd4:    begin mul_a = {e[0][32], e[0]}; mul_b = {e[4][32], e[4]}; end
          default: begin mul_a = {e[1][32], e[1]}; mul_b = {e[3][32], e[3]}; end
        endcase
      end
      S_SS: begin
        mul_a = {4'b0, vmag[k[1:0]][29:0]};
        mul_b = {4'b0, vmag[k[1:0]][29:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign eps_sq = {16'b0, cfg.normal_epsilon} * {16'b0, cfg.normal_epsilon};
  assign n_cnt  = seen + COUNT_BITS'(1);
  assign target = (cfg.facet_count == '0) ? COUNT_BITS'(1) : cfg.facet_count;
  assign mesh_done = (n_cnt >= target) || (n_cnt == '0);
  assign nn     = (n_cnt == '0) ? {1'b1, {COUNT_BITS{1'b0}}} : {1'b0, n_cnt};
  assign smag   = sum[k[1:0]][SUM_BITS-1] ? (~sum[k[1:0]] + SUM_BITS'(1)) : sum[k[1:0]];
  assign qclamp = (div_q > 64'd32767) ? 15'h7fff : div_q[14:0];

  always_comb begin
    for (int i = 0; i < 3; i++) vsel[i] = cur.vtx[k[1:0]][i];
  end

  // result assembly and push
  always_comb begin
    res = '0;
    res_push = 1'b0;
    if (state == S_VERT) begin
      res.kind = KIND_VERTEX;
      for (int i = 0; i < 3; i++) res.pos[i] = vsel[i];
      res.unit = unitv;
      res.last = (k == 3'd2) && !done_r;
      res_push = !res_full;
    end else if (state == S_SUM) begin
      case (k)
        3'd0: begin
          res.kind = KIND_MIN;
          for (int i = 0; i < 3; i++) res.pos[i] = bmin[i];
        end
        3'd1: begin
          res.kind = KIND_MAX;
          for (int i = 0; i < 3; i++) res.pos[i] = bmax[i];
        end
        default: begin
          res.kind = KIND_CENTER;
          res.pos  = cen;
          res.last = 1'b1;
        end
      endcase
      res_push = !res_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= 3'd0;
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      seen      <= '0;
      for (int i = 0; i < 3; i++) begin
        bmin[i] <= 32'sh7fffffff;
        bmax[i] <= -32'sh7fffffff - 32'sd1;
        sum[i]  <= '0;
      end
    end else begin
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      case (state)
        S_IDLE: begin
          if (facet_valid) begin
            cur   <= facet;
            k     <= 3'd0;
            state <= S_LEN;
          end
        end
        S_LEN: begin
          ss <= (k == 3'd0) ? prod[63:0] : ss + prod[63:0];
          k  <= k + 3'd1;
          if (k == 3'd2) state <= S_TEST;
        end
        S_TEST: begin
          if (ss < {32'b0, eps_sq}) begin
            for (int i = 0; i < 3; i++) begin
              e[i]   <= {cur.vtx[1][i][31], cur.vtx[1][i]} - {cur.vtx[0][i][31], cur.vtx[0][i]};
              e[3+i] <= {cur.vtx[2][i][31], cur.vtx[2][i]} - {cur.vtx[0][i][31], cur.vtx[0][i]};
            end
            state <= S_EDGE;
          end else begin
            for (int i = 0; i < 3; i++) vec[i] <= {{32{cur.nrm[i][31]}}, cur.nrm[i]};
            state <= S_NORM;
          end
        end
        S_EDGE: begin
          // halve all edges together until every component fits in 31 bits
          if (big) begin
            for (int i = 0; i < 6; i++) e[i] <= e[i] >>> 1;
          end else begin
            k     <= 3'd0;
            state <= S_CROSS;
          end
        end
        S_CROSS: begin
          if (!k[0]) vec[k[2:1]] <= prod[63:0];
          else       vec[k[2:1]] <= vec[k[2:1]] - prod[63:0];
          k <= k + 3'd1;
          if (k == 3'd5) state <= S_NORM;
        end
        S_NORM: begin
          if (m == 64'd0) begin
            unitv  <= '0;
            k      <= 3'd0;
            done_r <= mesh_done;
            state  <= S_VERT;
          end else if (m < M_LO) begin
            for (int i = 0; i < 3; i++) vec[i] <= vec[i] <<< 1;
          end else if (m >= M_HI) begin
            for (int i = 0; i < 3; i++) vec[i] <= vec[i] >>> 1;
          end else begin
            k     <= 3'd0;
            state <= S_SS;
          end
        end
        S_SS: begin
          ss <= (k == 3'd0) ? prod[63:0] : ss + prod[63:0];
          k  <= k + 3'd1;
          if (k == 3'd2) state <= S_SQRT_GO;
        end
        S_SQRT_GO: begin
          sq_start <= 1'b1;
          state    <= S_SQRT_WAIT;
        end
        S_SQRT_WAIT: begin
          if (sq_done) begin
            len   <= sq_root;
            k     <= 3'd0;
            state <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          div_num   <= {20'b0, vmag[k[1:0]][29:0], 14'b0} + {33'b0, len[31:1]};
          div_den   <= len;
          div_start <= 1'b1;
          state     <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            unitv[k[1:0]] <= vec[k[1:0]][63] ? (16'd0 - {1'b0, qclamp}) : {1'b0, qclamp};
            if (k == 3'd2) begin
              k      <= 3'd0;
              done_r <= mesh_done;
              state  <= S_VERT;
            end else begin
              k     <= k + 3'd1;
              state <= S_DIV_GO;
            end
          end
        end
        S_VERT: begin
          if (!res_full) begin
            for (int i = 0; i < 3; i++) begin
              if ($signed(vsel[i]) < bmin[i]) bmin[i] <= vsel[i];
              if ($signed(vsel[i]) > bmax[i]) bmax[i] <= vsel[i];
              sum[i] <= sum[i] + {{(SUM_BITS-32){vsel[i][31]}}, vsel[i]};
            end
            k <= k + 3'd1;
            if (k == 3'd2) begin
              seen    <= n_cnt;
              cen_den <= CDEN_BITS'({nn, 1'b0}) + CDEN_BITS'(nn);
              k       <= 3'd0;
              state   <= mesh_done ? S_CEN_GO : S_IDLE;
            end
          end
        end
        S_CEN_GO: begin
          div_num   <= 64'(smag) + 64'(cen_den[CDEN_BITS-1:1]);
          div_den   <= 32'(cen_den);
          div_start <= 1'b1;
          state     <= S_CEN_WAIT;
        end
        S_CEN_WAIT: begin
          if (div_done) begin
            cen[k[1:0]] <= sum[k[1:0]][SUM_BITS-1] ? (32'd0 - div_q[31:0]) : div_q[31:0];
            if (k == 3'd2) begin
              k     <= 3'd0;
              state <= S_SUM;
            end else begin
              k     <= k + 3'd1;
              state <= S_CEN_GO;
            end
          end
        end
        S_SUM: begin
          if (!res_full) begin
            k <= k + 3'd1;
            if (k == 3'd2) begin
              // drop mesh state for the next mesh
              seen <= '0;
              for (int i = 0; i < 3; i++) begin
                bmin[i] <= 32'sh7fffffff;
                bmax[i] <= -32'sh7fffffff - 32'sd1;
                sum[i]  <= '0;
              end
              k     <= 3'd0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_WAIT || state == S_CEN_WAIT))
    else $error("divider finished outside a wait state");
  a_sqrt_done_wait: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == S_SQRT_WAIT))
    else $error("square root finished outside its wait state");
  a_ss_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SS) |-> (m >= M_LO && m < M_HI))
    else $error("normalized vector out of range");
  a_take_len: assert property (@(posedge clk) disable iff (rst)
    facet_take |=> (state == S_LEN))
    else $error("facet taken without length pass");
`endif

endmodule

### verif/tb_top.sv
// Testbench for mesh_facet_normal_bounds_unit: facet normals, vertex results, bounds
// and centroid are checked against an in-bench predictor. Depends on mfnb_pkg and the unit.
`timescale 1ns / 1ps

module tb_top;
  import mfnb_pkg::*;

  localparam logic [7:0] CFG_UNUSED = 8'd2;   // an index the unit must drop
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [31:0] normal_x, normal_y, normal_z;
  logic [31:0] vertex0_x, vertex0_y, vertex0_z;
  logic [31:0] vertex1_x, vertex1_y, vertex1_z;
  logic [31:0] vertex2_x, vertex2_y, vertex2_z;
  logic        empty;
  logic        pop;
  logic [1:0]  kind;
  logic [31:0] pos_x, pos_y, pos_z;
  logic [15:0] unit_nx, unit_ny, unit_nz;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_data;

  mesh_facet_normal_bounds_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .vertex0_x(vertex0_x), .vertex0_y(vertex0_y), .vertex0_z(vertex0_z),
    .vertex1_x(vertex1_x), .vertex1_y(vertex1_y), .vertex1_z(vertex1_z),
    .vertex2_x(vertex2_x), .vertex2_y(vertex2_y), .vertex2_z(vertex2_z),
    .empty(empty), .pop(pop), .kind(kind),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .unit_nx(unit_nx), .unit_ny(unit_ny), .unit_nz(unit_nz), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Clock: 12 ns period.
  always #6 clk = ~clk;

  // Mirror of the unit's registers and mesh state.
  logic [COUNT_BITS-1:0] mesh_facets;
  logic [15:0]           len_threshold;
  longint                lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  longint                acc_x, acc_y, acc_z;
  logic [COUNT_BITS-1:0] facets_in_mesh;

  result_t pending_results[$];
  int      mismatches;
  int      burst_left;
  int      stall_pct;
  int      stall_age;

  task automatic clear_mesh_state();
    lo_x = Q_MAX; lo_y = Q_MAX; lo_z = Q_MAX;
    hi_x = Q_MIN; hi_y = Q_MIN; hi_z = Q_MIN;
    acc_x = 0; acc_y = 0; acc_z = 0;
    facets_in_mesh = '0;
  endtask

  function automatic longint unsigned absval(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale the vector into [2^29, 2^30), then divide each component by its length.
  function automatic logic [2:0][15:0] unit_normal(longint vx, longint vy, longint vz);
    longint          v[3];
    longint unsigned m, ss, len, q;
    logic [2:0][15:0] u;
    v[0] = vx; v[1] = vy; v[2] = vz;
    u = '0;
    m = 0;
    for (int i = 0; i < 3; i++) if (absval(v[i]) > m) m = absval(v[i]);
    if (m == 0) return u;
    while (m < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) v[i] = v[i] * 2;
      m = m * 2;
    end
    while (m >= (64'd1 << 30)) begin
      m = 0;
      for (int i = 0; i < 3; i++) begin
        v[i] = v[i] >>> 1;
        if (absval(v[i]) > m) m = absval(v[i]);
      end
    end
    ss = 0;
    for (int i = 0; i < 3; i++) ss = ss + absval(v[i]) * absval(v[i]);
    len = floor_sqrt(ss);
    for (int i = 0; i < 3; i++) begin
      q = (absval(v[i]) * 16384 + len / 2) / len;
      if (q > 32767) q = 32767;
      u[i] = v[i] < 0 ? 16'(-longint'(q)) : 16'(q);
    end
    return u;
  endfunction

  function automatic longint centroid_axis(longint s, longint unsigned den);
    longint          s58;
    longint unsigned q;
    s58 = (s <<< 6) >>> 6;   // sums wrap at 58 bits
    q = (absval(s58) + den / 2) / den;
    return s58 < 0 ? -longint'(q) : longint'(q);
  endfunction

  // Work out the three vertex results, and the summary on a mesh end, for one facet.
  task automatic predict_facet_results(facet_t f);
    longint           nrm[3], vx[3][3], e[6], vec[3];
    longint unsigned  ss, m, den;
    logic [2:0][15:0] u;
    logic [COUNT_BITS-1:0] n, target;
    logic             done;
    result_t          r;
    ss = 0;
    for (int i = 0; i < 3; i++) begin
      nrm[i] = longint'($signed(f.nrm[i]));
      ss = ss + absval(nrm[i]) * absval(nrm[i]);   // wraps at 64 bits
      for (int k = 0; k < 3; k++) vx[k][i] = longint'($signed(f.vtx[k][i]));
    end
    if (ss < longint'(len_threshold) * longint'(len_threshold)) begin
      for (int i = 0; i < 3; i++) begin
        e[i] = vx[1][i] - vx[0][i];
        e[3 + i] = vx[2][i] - vx[0][i];
      end
      forever begin
        m = 0;
        for (int i = 0; i < 6; i++) if (absval(e[i]) > m) m = absval(e[i]);
        if (m < (64'd1 << 30)) break;
        for (int i = 0; i < 6; i++) e[i] = e[i] >>> 1;
      end
      vec[0] = e[1] * e[5] - e[2] * e[4];
      vec[1] = e[2] * e[3] - e[0] * e[5];
      vec[2] = e[0] * e[4] - e[1] * e[3];
    end else begin
      for (int i = 0; i < 3; i++) vec[i] = nrm[i];
    end
    u = unit_normal(vec[0], vec[1], vec[2]);

    n = facets_in_mesh + 1'b1;
    target = (mesh_facets == '0) ? COUNT_BITS'(1) : mesh_facets;
    done = (n >= target) || (n == 0);

    for (int k = 0; k < 3; k++) begin
      r.kind = KIND_VERTEX;
      for (int i = 0; i < 3; i++) r.pos[i] = vx[k][i][31:0];
      r.unit = u;
      r.last = (k == 2) && !done;
      pending_results.push_back(r);
      if (vx[k][0] < lo_x) lo_x = vx[k][0];
      if (vx[k][1] < lo_y) lo_y = vx[k][1];
      if (vx[k][2] < lo_z) lo_z = vx[k][2];
      if (vx[k][0] > hi_x) hi_x = vx[k][0];
      if (vx[k][1] > hi_y) hi_y = vx[k][1];
      if (vx[k][2] > hi_z) hi_z = vx[k][2];
      acc_x = acc_x + vx[k][0];
      acc_y = acc_y + vx[k][1];
      acc_z = acc_z + vx[k][2];
    end
    facets_in_mesh = n;
    if (done) begin
      den = 3 * (n == 0 ? (64'd1 << COUNT_BITS) : longint'(n));
      r = '0;
      r.kind = KIND_MIN;
      r.pos[0] = lo_x[31:0]; r.pos[1] = lo_y[31:0]; r.pos[2] = lo_z[31:0];
      pending_results.push_back(r);
      r.kind = KIND_MAX;
      r.pos[0] = hi_x[31:0]; r.pos[1] = hi_y[31:0]; r.pos[2] = hi_z[31:0];
      pending_results.push_back(r);
      r.kind = KIND_CENTER;
      r.pos[0] = 32'(centroid_axis(acc_x, den));
      r.pos[1] = 32'(centroid_axis(acc_y, den));
      r.pos[2] = 32'(centroid_axis(acc_z, den));
      r.last = 1'b1;
      pending_results.push_back(r);
      clear_mesh_state();
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Send one facet; the transfer happens on the first edge with full low.
  // Push stays high between items of a burst and drops only for a gap.
  task automatic send_facet(facet_t f);
    normal_x  <= f.nrm[0];    normal_y  <= f.nrm[1];    normal_z  <= f.nrm[2];
    vertex0_x <= f.vtx[0][0]; vertex0_y <= f.vtx[0][1]; vertex0_z <= f.vtx[0][2];
    vertex1_x <= f.vtx[1][0]; vertex1_y <= f.vtx[1][1]; vertex1_z <= f.vtx[1][2];
    vertex2_x <= f.vtx[2][0]; vertex2_y <= f.vtx[2][1]; vertex2_z <= f.vtx[2][2];
    push <= 1'b1;
    do @(posedge clk); while (full);
    predict_facet_results(f);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      // Mostly short bursts, sometimes a long run with no gaps.
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 4);
    end
  endtask

  // Drop push and wait until every expected result has been popped, then let the
  // unit settle before any register write.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_FACET_COUNT) mesh_facets = value[COUNT_BITS-1:0];
    else if (idx == CFG_NORMAL_EPSILON) len_threshold = value[15:0];
    @(posedge clk);
  endtask

  function automatic facet_t make_facet(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                                        logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                        logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                                        logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
    facet_t f;
    f.nrm[0] = nx; f.nrm[1] = ny; f.nrm[2] = nz;
    f.vtx[0][0] = ax; f.vtx[0][1] = ay; f.vtx[0][2] = az;
    f.vtx[1][0] = bx; f.vtx[1][1] = by; f.vtx[1][2] = bz;
    f.vtx[2][0] = cx; f.vtx[2][1] = cy; f.vtx[2][2] = cz;
    return f;
  endfunction

  function automatic logic [31:0] near(int r);
    return 32'($urandom_range(0, 2 * r)) - 32'(r);
  endfunction

  // Random facet: mixes full-range, small, degenerate and collinear triangles with
  // zero, sub-threshold, unit-sized and full-range stored normals.
  function automatic facet_t random_facet();
    facet_t f;
    int     vmode, nmode;
    vmode = $urandom_range(0, 9);
    nmode = $urandom_range(0, 19);
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 3; i++)
        f.vtx[k][i] = (vmode < 4) ? $urandom() : near(1 << 20);
    if (vmode == 8) begin
      f.vtx[1] = f.vtx[0];
      f.vtx[2] = f.vtx[0];
    end else if (vmode == 9) begin
      for (int i = 0; i < 3; i++) f.vtx[2][i] = 2 * f.vtx[1][i] - f.vtx[0][i];
    end
    for (int i = 0; i < 3; i++) begin
      if (nmode < 6) f.nrm[i] = '0;
      else if (nmode < 10) f.nrm[i] = near(len_threshold / 2);
      else if (nmode < 15) f.nrm[i] = near(1 << 16);
      else f.nrm[i] = $urandom();
    end
    return f;
  endfunction

  // Receiver: check each popped result against the oldest expectation; stall on a
  // random pattern whose density is redrawn each time its age counter runs out.
  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result kind", kind, 0);
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind) report_mismatch("kind", kind, want.kind);
        if (pos_x !== want.pos[0]) report_mismatch("pos_x", pos_x, want.pos[0]);
        if (pos_y !== want.pos[1]) report_mismatch("pos_y", pos_y, want.pos[1]);
        if (pos_z !== want.pos[2]) report_mismatch("pos_z", pos_z, want.pos[2]);
        if (unit_nx !== want.unit[0]) report_mismatch("unit_nx", unit_nx, want.unit[0]);
        if (unit_ny !== want.unit[1]) report_mismatch("unit_ny", unit_ny, want.unit[1]);
        if (unit_nz !== want.unit[2]) report_mismatch("unit_nz", unit_nz, want.unit[2]);
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
    end
    if (stall_age == 0) begin
      stall_age = $urandom_range(50, 300);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 30;
        2: stall_pct = 70;
        default: stall_pct = 95;
      endcase
    end
    stall_age--;
    pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Field extremes, both normal sources, zero normals and the halving of wide edges.
  task automatic test_directed_facets();
    send_facet(make_facet(0, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0));
    send_facet(make_facet(32'h10000, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0));
    send_facet(make_facet(32'h80000000, 32'h80000000, 32'h80000000,
                          32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 1,
                          32'h80000000, 32'h80000000, 32'h7fffffff));
    send_facet(make_facet(32'hffffffff, 32'hffffffff, 32'hffffffff,
                          32'hffffffff, 32'hffffffff, 32'hffffffff,
                          32'hffffffff, 32'hffffffff, 32'hffffffff,
                          32'hffffffff, 32'hffffffff, 32'hffffffff));
    // Zero normal with a degenerate and a collinear triangle: zero unit normal.
    send_facet(make_facet(0, 0, 0, 5, 6, 7, 5, 6, 7, 5, 6, 7));
    send_facet(make_facet(0, 0, 0, 0, 0, 0, 32'h30000, 32'h20000, 1, 32'h60000, 32'h40000, 2));
    // Tiny stored normal, at the threshold: scaled up by doubling.
    send_facet(make_facet(1, 0, 0, 1, 2, 3, 4, 5, 6, 7, 8, 10));
    send_facet(make_facet(0, 32'hfffffffb, 3, 32'h12345678, 32'hedcba987, 32'h0f0f0f0f,
                          32'h55555555, 32'haaaaaaaa, 32'h33333333,
                          32'hcccccccc, 32'h00ff00ff, 32'hff00ff00));
    wait_idle();
    // Threshold zero: a zero stored normal is still used.
    write_reg(CFG_NORMAL_EPSILON, 0);
    send_facet(make_facet(0, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0));
    wait_idle();
    // Largest threshold: a length just at it keeps the stored normal, just under swaps.
    write_reg(CFG_NORMAL_EPSILON, 32'hffff);
    send_facet(make_facet(32'hffff, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000));
    send_facet(make_facet(32'hfffe, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000));
    send_facet(make_facet(32'hb504, 32'hb504, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000));
    wait_idle();
  endtask

  // Mesh sizes: three facets, zero acting as one, and the largest count cut short.
  task automatic test_mesh_sizes();
    write_reg(CFG_NORMAL_EPSILON, 1);
    write_reg(CFG_FACET_COUNT, 3);
    write_reg(CFG_UNUSED, 32'hffffffff);
    repeat (3) send_facet(random_facet());
    wait_idle();
    write_reg(CFG_FACET_COUNT, 0);
    repeat (2) send_facet(random_facet());
    wait_idle();
    write_reg(CFG_FACET_COUNT, 32'hffffff);
    repeat (2) send_facet(random_facet());
    wait_idle();
    write_reg(CFG_FACET_COUNT, 1);
    send_facet(random_facet());
    wait_idle();
  endtask

  // Random phases, each with its own mesh size and threshold.
  task automatic test_random_meshes();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: write_reg(CFG_FACET_COUNT, $urandom_range(1, 3));
        1: write_reg(CFG_FACET_COUNT, $urandom_range(4, 12));
        default: write_reg(CFG_FACET_COUNT, $urandom_range(13, 40));
      endcase
      case (phase)
        0: write_reg(CFG_NORMAL_EPSILON, 0);
        1: write_reg(CFG_NORMAL_EPSILON, 32'hffff);
        default: write_reg(CFG_NORMAL_EPSILON, $urandom_range(0, 65535));
      endcase
      repeat (58) send_facet(random_facet());
      wait_idle();
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    {normal_x, normal_y, normal_z} = '0;
    {vertex0_x, vertex0_y, vertex0_z} = '0;
    {vertex1_x, vertex1_y, vertex1_z} = '0;
    {vertex2_x, vertex2_y, vertex2_z} = '0;
    mismatches = 0;
    burst_left = 0;
    stall_pct = 0;
    stall_age = 0;
    mesh_facets = 1;
    len_threshold = 1;
    clear_mesh_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_facets();
    test_mesh_sizes();
    test_random_meshes();

    // Everything has drained; give the unit a little longer for stray results.
    repeat (400) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("mesh_facet_normal_bounds_unit regression: pass");
    end else begin
      $display("mesh_facet_normal_bounds_unit regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #30ms;
    $display("mesh_facet_normal_bounds_unit regression: fail");
    $finish;
  end

endmodule

### filelist.f
sv/mfnb_pkg.sv
sv/mfnb_front.sv
sv/mfnb_outq.sv
sv/mfnb_div.sv
sv/mfnb_sqrt.sv
sv/mfnb_back.sv
sv/mesh_facet_normal_bounds_unit.sv
verif/tb_top.sv
